FILE: rtl/finite_difference_derivatives_top_defines.svh
// ---------------------------------------------------------------------------
// finite difference derivatives - assertion macros
// shared property shapes for the checker
// ---------------------------------------------------------------------------
`ifndef FINITE_DIFFERENCE_DERIVATIVES_TOP_DEFINES_SVH
`define FINITE_DIFFERENCE_DERIVATIVES_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define FDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fdd assertion failed");

// next-cycle implication, off while in reset
`define FDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fdd assertion failed");

// next-cycle implication, always checked
`define FDD_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fdd assertion failed");

`endif

FILE: rtl/fdd_pkg.sv
// ---------------------------------------------------------------------------
// fdd_pkg
// types and constants of the finite difference derivative block
// ---------------------------------------------------------------------------
`default_nettype none

package fdd_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int RECIP_BITS     = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_INV_TWO_DT     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INV_DT_SQUARED = 2'd1;

    localparam logic [RECIP_BITS-1:0] INV_TWO_DT_RESET     = 32'd6554;
    localparam logic [RECIP_BITS-1:0] INV_DT_SQUARED_RESET = 32'd2621;

    typedef enum logic [1:0] {
        KIND_FORWARD  = 2'd0,
        KIND_CENTRAL  = 2'd1,
        KIND_BACKWARD = 2'd2,
        KIND_SHORT    = 2'd3
    } t_kind;

    // pending result jobs of one sample, lowest bit goes out first
    localparam int JOB_FORWARD  = 0;
    localparam int JOB_CENTRAL1 = 1;
    localparam int JOB_CENTRAL2 = 2;
    localparam int JOB_BACKWARD = 3;
    localparam int JOB_SHORT    = 4;
    localparam int JOB_COUNT    = 5;

    typedef logic [JOB_COUNT-1:0] t_jobs;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

`default_nettype wire

FILE: rtl/fdd_in_if.sv
// ---------------------------------------------------------------------------
// fdd_in_if
// sample channel: position and final mark
// ---------------------------------------------------------------------------
`default_nettype none

interface fdd_in_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] position;
    logic                          final_sample;

    modport source (output valid, output position, output final_sample, input ready);
    modport sink   (input valid, input position, input final_sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/fdd_out_if.sv
// ---------------------------------------------------------------------------
// fdd_out_if
// result channel: derivatives and flags
// ---------------------------------------------------------------------------
`default_nettype none

interface fdd_out_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] velocity;
    logic signed [SAMPLE_BITS-1:0] acceleration;
    fdd_pkg::t_kind                formula_kind;
    logic                          saturated;
    logic                          end_of_run;

    modport source (
        output valid, output velocity, output acceleration, output formula_kind,
        output saturated, output end_of_run, input ready
    );
    modport sink (
        input valid, input velocity, input acceleration, input formula_kind,
        input saturated, input end_of_run, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/fdd_cfg_if.sv
// ---------------------------------------------------------------------------
// fdd_cfg_if
// register write channel
// ---------------------------------------------------------------------------
`default_nettype none

interface fdd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [fdd_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [fdd_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/fdd_scale.sv
// ---------------------------------------------------------------------------
// fdd_scale
// numerator times reciprocal, rounded half away from zero, saturated
// ---------------------------------------------------------------------------
`default_nettype none

module fdd_scale #(
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 16,
    localparam int NUM_BITS     = SAMPLE_BITS + 4
) (
    input  wire logic                          i_clk,
    input  wire fdd_pkg::t_stage_en            i_en,
    input  wire logic signed [NUM_BITS-1:0]    i_num,
    input  wire logic [fdd_pkg::RECIP_BITS-1:0] i_recip,
    output logic signed [SAMPLE_BITS-1:0]      o_value,
    output logic                               o_sat
);

    localparam int RB       = fdd_pkg::RECIP_BITS;
    localparam int MAG_BITS = NUM_BITS;
    localparam int LO_BITS  = (MAG_BITS < 32) ? MAG_BITS : 32;
    localparam int HI_BITS  = (MAG_BITS > 32) ? MAG_BITS - 32 : 1;
    localparam int EXT_BITS = HI_BITS + 32;
    localparam int SUM_BITS = HI_BITS + RB + 33;
    localparam logic [SUM_BITS-1:0] HALF = (SUM_BITS'(1) << FRACTION_BITS) >> 1;
    localparam logic [SUM_BITS-1:0] POS_LIM = (SUM_BITS'(1) << (SAMPLE_BITS - 1)) - 1'b1;

    // magnitude stage
    logic                  r_neg2;
    logic [MAG_BITS-1:0]   r_mag;
    logic                  n_neg2;
    logic [MAG_BITS-1:0]   n_mag;

    // product stage
    logic                  r_neg3;
    logic [LO_BITS+RB-1:0] r_plo;
    logic [HI_BITS+RB-1:0] r_phi;
    logic [EXT_BITS-1:0]   w_mag_ext;
    logic [LO_BITS-1:0]    w_lo;
    logic [HI_BITS-1:0]    w_hi;

    // round and clip stage
    logic [SUM_BITS-1:0]    w_sum;
    logic [SUM_BITS-1:0]    w_q;
    logic [SUM_BITS-1:0]    w_lim;
    logic                   w_clip;
    logic [SAMPLE_BITS-1:0] w_qmag;
    logic [SAMPLE_BITS-1:0] n_value;

    always_comb begin
        n_neg2 = i_num[NUM_BITS-1];
        n_mag  = n_neg2 ? (~MAG_BITS'(i_num) + 1'b1) : MAG_BITS'(i_num);
    end

    assign w_mag_ext = EXT_BITS'(r_mag);
    assign w_lo      = w_mag_ext[LO_BITS-1:0];
    assign w_hi      = w_mag_ext[32 +: HI_BITS];

    always_comb begin
        w_sum   = {1'b0, r_phi, 32'd0} + SUM_BITS'(r_plo) + HALF;
        w_q     = w_sum >> FRACTION_BITS;
        w_lim   = POS_LIM + SUM_BITS'(r_neg3);
        w_clip  = (w_q > w_lim);
        w_qmag  = w_clip ? w_lim[SAMPLE_BITS-1:0] : w_q[SAMPLE_BITS-1:0];
        n_value = r_neg3 ? (~w_qmag + 1'b1) : w_qmag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_neg2 <= n_neg2;
            r_mag  <= n_mag;
        end
        if (i_en.s3) begin
            r_neg3 <= r_neg2;
            r_plo  <= {{RB{1'b0}}, w_lo} * {{LO_BITS{1'b0}}, i_recip};
            r_phi  <= {{RB{1'b0}}, w_hi} * {{HI_BITS{1'b0}}, i_recip};
        end
        if (i_en.s4) begin
            o_value <= n_value;
            o_sat   <= w_clip;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/finite_difference_derivatives_top.sv
// ---------------------------------------------------------------------------
// finite_difference_derivatives_top
// first and second derivatives of a stream of equally spaced samples
// ---------------------------------------------------------------------------
// Samples enter on i_sample (valid/ready); a transaction is accepted when
// both are high. final_sample marks the last sample of a series. Results
// leave on o_result (valid/ready); i_cfg writes the two reciprocals and is
// always ready.
// Samples 0 to 2 of a series give no result. Sample 3 gives three results
// (forward, central, central); every later sample gives one central result;
// a final sample adds its backward result with end_of_run set. A series of
// fewer than four samples gives one result of kind short.
// Latency: the first result of a sample is valid after it passes the job
// register, numerator, magnitude, multiply and round/clip stages in order.
// Throughput: one sample per cycle while each gives one result and o_result
// does not stall; a sample with more than one result holds i_sample.ready
// low until its last is dispatched to the single shared pair of scalers.
// Reset clears the window, the sample count, pending jobs and all stage
// valid bits, and loads the reset reciprocals. When the receiver stalls,
// empty stages still fill, so samples keep being taken until the pipeline
// is full; the held result stays stable on o_result.
// ---------------------------------------------------------------------------
`default_nettype none

module finite_difference_derivatives_top #(
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 16
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    fdd_in_if.sink     i_sample,
    fdd_out_if.source  o_result,
    fdd_cfg_if.sink    i_cfg
);

    localparam int NUM_BITS = SAMPLE_BITS + 4;
    localparam int RB       = fdd_pkg::RECIP_BITS;

    logic [RB-1:0] r_inv_two_dt;
    logic [RB-1:0] r_inv_dt_squared;

    logic signed [SAMPLE_BITS-1:0] r_win [4];
    logic signed [SAMPLE_BITS-1:0] r_jwin [4];
    logic signed [SAMPLE_BITS-1:0] w_shift [4];
    logic [1:0]                    r_seen;
    logic                          r_primed;
    fdd_pkg::t_jobs                r_jobs;
    fdd_pkg::t_jobs                n_jobs;
    fdd_pkg::t_jobs                w_pick;
    fdd_pkg::t_jobs                w_jobs_left;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;
    logic w_dispatch;
    logic w_accept;
    fdd_pkg::t_stage_en w_en;

    logic signed [NUM_BITS-1:0] r_vnum, r_anum;
    logic signed [NUM_BITS-1:0] n_vnum, n_anum;
    fdd_pkg::t_kind r_kind1, r_kind2, r_kind3, r_kind4;
    fdd_pkg::t_kind n_kind1;
    logic r_end1, r_end2, r_end3, r_end4;
    logic n_end1;

    logic signed [SAMPLE_BITS-1:0] w_velocity, w_acceleration;
    logic w_vsat, w_asat;

    // stage enables, a stage moves when its successor is empty or moving
    assign w_en4 = !r_v4 || o_result.ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign w_en  = '{s2: w_en2, s3: w_en3, s4: w_en4};

    assign w_pick      = r_jobs & (~r_jobs + 1'b1);
    assign w_dispatch  = (r_jobs != '0) && w_en1;
    assign w_jobs_left = w_dispatch ? (r_jobs & ~w_pick) : r_jobs;

    assign i_sample.ready = (w_jobs_left == '0);
    assign w_accept       = i_sample.valid && i_sample.ready;
    assign i_cfg.ready    = 1'b1;

    assign w_shift[0] = r_win[1];
    assign w_shift[1] = r_win[2];
    assign w_shift[2] = r_win[3];
    assign w_shift[3] = i_sample.position;

    always_comb begin
        n_jobs = '0;
        if (!r_primed && r_seen < 2'd3) begin
            n_jobs[fdd_pkg::JOB_SHORT] = i_sample.final_sample;
        end else begin
            n_jobs[fdd_pkg::JOB_FORWARD]  = !r_primed;
            n_jobs[fdd_pkg::JOB_CENTRAL1] = !r_primed;
            n_jobs[fdd_pkg::JOB_CENTRAL2] = 1'b1;
            n_jobs[fdd_pkg::JOB_BACKWARD] = i_sample.final_sample;
        end
    end

    // numerators of the next job
    always_comb begin
        logic signed [NUM_BITS-1:0] x0, x1, x2, x3;
        x0 = NUM_BITS'(r_jwin[0]);
        x1 = NUM_BITS'(r_jwin[1]);
        x2 = NUM_BITS'(r_jwin[2]);
        x3 = NUM_BITS'(r_jwin[3]);
        n_vnum  = '0;
        n_anum  = '0;
        n_kind1 = fdd_pkg::KIND_SHORT;
        n_end1  = 1'b1;
        priority if (r_jobs[fdd_pkg::JOB_FORWARD]) begin
            n_vnum  = (x1 <<< 2) - x2 - (x0 <<< 1) - x0;
            n_anum  = (x2 <<< 2) - x3 - (x1 <<< 2) - x1 + (x0 <<< 1);
            n_kind1 = fdd_pkg::KIND_FORWARD;
            n_end1  = 1'b0;
        end else if (r_jobs[fdd_pkg::JOB_CENTRAL1]) begin
            n_vnum  = x2 - x0;
            n_anum  = x2 - (x1 <<< 1) + x0;
            n_kind1 = fdd_pkg::KIND_CENTRAL;
            n_end1  = 1'b0;
        end else if (r_jobs[fdd_pkg::JOB_CENTRAL2]) begin
            n_vnum  = x3 - x1;
            n_anum  = x3 - (x2 <<< 1) + x1;
            n_kind1 = fdd_pkg::KIND_CENTRAL;
            n_end1  = 1'b0;
        end else if (r_jobs[fdd_pkg::JOB_BACKWARD]) begin
            n_vnum  = x1 - (x2 <<< 2) + (x3 <<< 1) + x3;
            n_anum  = (x1 <<< 2) - x0 - (x2 <<< 2) - x2 + (x3 <<< 1);
            n_kind1 = fdd_pkg::KIND_BACKWARD;
            n_end1  = 1'b1;
        end else begin
            n_vnum  = '0;
            n_anum  = '0;
            n_kind1 = fdd_pkg::KIND_SHORT;
            n_end1  = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_two_dt     <= fdd_pkg::INV_TWO_DT_RESET;
            r_inv_dt_squared <= fdd_pkg::INV_DT_SQUARED_RESET;
            for (int i = 0; i < 4; i++) begin
                r_win[i] <= '0;
            end
            r_seen   <= '0;
            r_primed <= 1'b0;
            r_jobs   <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == fdd_pkg::REG_INV_TWO_DT) begin
                    r_inv_two_dt <= i_cfg.data;
                end else if (i_cfg.index == fdd_pkg::REG_INV_DT_SQUARED) begin
                    r_inv_dt_squared <= i_cfg.data;
                end
            end
            if (w_accept) begin
                r_jobs <= n_jobs;
                if (i_sample.final_sample) begin
                    for (int i = 0; i < 4; i++) begin
                        r_win[i] <= '0;
                    end
                    r_seen   <= '0;
                    r_primed <= 1'b0;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        r_win[i] <= w_shift[i];
                    end
                    if (!r_primed && r_seen < 2'd3) begin
                        r_seen <= r_seen + 2'd1;
                    end else begin
                        r_primed <= 1'b1;
                    end
                end
            end else begin
                r_jobs <= w_jobs_left;
            end
            if (w_en1) begin
                r_v1 <= w_dispatch;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < 4; i++) begin
                r_jwin[i] <= w_shift[i];
            end
        end
        if (w_en1) begin
            r_vnum  <= n_vnum;
            r_anum  <= n_anum;
            r_kind1 <= n_kind1;
            r_end1  <= n_end1;
        end
        if (w_en2) begin
            r_kind2 <= r_kind1;
            r_end2  <= r_end1;
        end
        if (w_en3) begin
            r_kind3 <= r_kind2;
            r_end3  <= r_end2;
        end
        if (w_en4) begin
            r_kind4 <= r_kind3;
            r_end4  <= r_end3;
        end
    end

    fdd_scale #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_scale_vel (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (r_vnum),
        .i_recip (r_inv_two_dt),
        .o_value (w_velocity),
        .o_sat   (w_vsat)
    );

    fdd_scale #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_scale_acc (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (r_anum),
        .i_recip (r_inv_dt_squared),
        .o_value (w_acceleration),
        .o_sat   (w_asat)
    );

    assign o_result.valid        = r_v4;
    assign o_result.velocity     = w_velocity;
    assign o_result.acceleration = w_acceleration;
    assign o_result.formula_kind = r_kind4;
    assign o_result.saturated    = w_vsat || w_asat;
    assign o_result.end_of_run   = r_end4;

endmodule

`default_nettype wire

FILE: rtl/fdd_checker.sv
// ---------------------------------------------------------------------------
// fdd_checker
// port-level checks on the result channel, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "finite_difference_derivatives_top_defines.svh"

module fdd_checker #(
    parameter int SAMPLE_BITS = 32
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic signed [SAMPLE_BITS-1:0] i_velocity,
    input wire logic signed [SAMPLE_BITS-1:0] i_acceleration,
    input wire fdd_pkg::t_kind                i_formula_kind,
    input wire logic                          i_saturated,
    input wire logic                          i_end_of_run
);

    `FDD_ASSERT_NXT_ALL(a_reset_empties, i_clk, !i_rst_n, !i_out_valid)

    `FDD_ASSERT_NXT(a_valid_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    `FDD_ASSERT_NXT(a_payload_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_velocity) && $stable(i_acceleration) && $stable(i_formula_kind) && $stable(i_saturated) && $stable(i_end_of_run))

    `FDD_ASSERT_IMP(a_end_kind, i_clk, i_rst_n, i_out_valid, i_end_of_run == (i_formula_kind == fdd_pkg::KIND_BACKWARD || i_formula_kind == fdd_pkg::KIND_SHORT))

    `FDD_ASSERT_IMP(a_short_zero, i_clk, i_rst_n, i_out_valid && i_formula_kind == fdd_pkg::KIND_SHORT, i_velocity == '0 && i_acceleration == '0 && !i_saturated)

endmodule

bind finite_difference_derivatives_top fdd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fdd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_velocity     (o_result.velocity),
    .i_acceleration (o_result.acceleration),
    .i_formula_kind (o_result.formula_kind),
    .i_saturated    (o_result.saturated),
    .i_end_of_run   (o_result.end_of_run)
);

`default_nettype wire
